// ===== sv/rcnt_pkg.sv =====
// shared types, constants and codes for the three-channel root counter
`default_nettype none

package rcnt_pkg;

	localparam int NUM_TIMERS = 3;
	localparam int TIMER_W    = 2;
	localparam int CNT_W      = 16;
	localparam int MODE_W     = 13;
	localparam int HOLD_W     = 7;
	localparam int DIV_W      = 3;

	// interrupt hold time in ticks and the slow clock divider
	localparam logic [HOLD_W-1:0] IRQ_HOLD_TICKS = 7'd100;
	localparam logic [DIV_W:0]    SLOW_DIVIDE    = 4'd8;

	localparam logic [CNT_W-1:0]  CNT_MAX = 16'hFFFF;

	// timer that runs off the divided system clock
	localparam logic [TIMER_W-1:0] TIMER_SLOW = 2'd2;

	// mode register bit positions
	localparam int MB_SYNC      = 0;
	localparam int MB_SYNC_LO   = 1;
	localparam int MB_SYNC_HI   = 2;
	localparam int MB_RESET_TGT = 3;
	localparam int MB_IRQ_TGT   = 4;
	localparam int MB_IRQ_MAX   = 5;
	localparam int MB_SRC_LO    = 8;
	localparam int MB_SRC_HI    = 9;
	localparam int MB_REQ       = 10;
	localparam int MB_HIT_TGT   = 11;
	localparam int MB_HIT_MAX   = 12;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_HBLANK = 3'd1,
		OP_VBLANK = 3'd2,
		OP_READ   = 3'd3,
		OP_WRITE  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REG_COUNT  = 2'd0,
		REG_MODE   = 2'd1,
		REG_TARGET = 2'd2
	} reg_sel_t;

	typedef enum logic [1:0] {
		SYNC_PAUSE     = 2'd0,
		SYNC_RESET     = 2'd1,
		SYNC_RESET_RUN = 2'd2,
		SYNC_FREE      = 2'd3
	} sync_t;

	typedef struct packed {
		logic [2:0]       operation;
		logic [1:0]       timer_select;
		logic [1:0]       reg_select;
		logic [CNT_W-1:0] write_data;
		logic             blank_level;
		logic             dot_pulse;
		logic             line_pulse;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0]      read_data;
		logic [NUM_TIMERS-1:0] irq_lines;
	} rsp_t;

endpackage

`default_nettype wire

// ===== sv/rcnt_if.sv =====
// valid/ready channel interfaces for requests and responses
`default_nettype none

interface rcnt_req_if;
	logic          valid;
	logic          ready;
	rcnt_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rcnt_rsp_if;
	logic          valid;
	logic          ready;
	rcnt_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/rcnt_core.sv =====
// counter, mode, target and interrupt state with the per-item update logic
`default_nettype none

module rcnt_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire rcnt_pkg::req_t item,
	output rcnt_pkg::rsp_t      result
);
	import rcnt_pkg::*;

	logic [NUM_TIMERS-1:0][CNT_W-1:0]  cnt_q, cnt_d;
	logic [NUM_TIMERS-1:0][CNT_W-1:0]  tgt_q, tgt_d;
	logic [NUM_TIMERS-1:0][MODE_W-1:0] mode_q, mode_d;
	logic [NUM_TIMERS-1:0][HOLD_W-1:0] hold_q, hold_d;
	logic [NUM_TIMERS-1:0]             run_q, run_d;
	logic [NUM_TIMERS-1:0]             irq_q, irq_d;
	logic [DIV_W-1:0]                  div_q, div_d;

	logic [NUM_TIMERS-1:0][CNT_W-1:0]  nxt;
	logic [NUM_TIMERS-1:0]             adv, hit, top, cond;
	logic [DIV_W:0]                    div_inc;
	logic                              slow;
	logic                              do_irq;
	logic [CNT_W-1:0]                  rd;
	logic [TIMER_W-1:0]                bi;
	logic [TIMER_W-1:0]                t;
	logic [MODE_W-1:0]                 nm;
	logic [1:0]                        sm;
	logic                              timer_ok;

	assign t        = item.timer_select;
	assign timer_ok = (t < TIMER_W'(NUM_TIMERS));

	always_comb begin
		cnt_d   = cnt_q;
		tgt_d   = tgt_q;
		mode_d  = mode_q;
		hold_d  = hold_q;
		run_d   = run_q;
		irq_d   = irq_q;
		div_d   = div_q;
		nxt     = '0;
		adv     = '0;
		hit     = '0;
		top     = '0;
		cond    = '0;
		div_inc = '0;
		slow    = 1'b0;
		do_irq  = 1'b0;
		rd      = '0;
		bi      = '0;
		nm      = '0;
		sm      = '0;
		unique case (item.operation)
			OP_TICK: begin
				// interrupt hold expiry
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (hold_d[i] != '0) begin
						hold_d[i] = hold_d[i] - 1'b1;
						if (hold_d[i] == '0) begin
							irq_d[i]          = 1'b0;
							mode_d[i][MB_REQ] = 1'b1;
						end
					end
				end
				div_inc = {1'b0, div_q} + 1'b1;
				slow    = (div_inc >= SLOW_DIVIDE);
				div_d   = slow ? '0 : div_inc[DIV_W-1:0];
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (i == 0)
						adv[i] = mode_d[i][MB_SRC_LO] ? item.dot_pulse : 1'b1;
					else if (i == 1)
						adv[i] = mode_d[i][MB_SRC_LO] ? item.line_pulse : 1'b1;
					else
						adv[i] = mode_d[i][MB_SRC_HI] ? slow : 1'b1;
					nxt[i] = cnt_q[i] + 1'b1;
					hit[i] = (nxt[i] == tgt_q[i]);
					top[i] = (nxt[i] == CNT_MAX);
					if (run_q[i] && adv[i]) begin
						if (hit[i]) mode_d[i][MB_HIT_TGT] = 1'b1;
						if (top[i]) mode_d[i][MB_HIT_MAX] = 1'b1;
						if (hit[i] || top[i]) do_irq = 1'b1;
						if (top[i] || (hit[i] && mode_d[i][MB_RESET_TGT]))
							cnt_d[i] = '0;
						else
							cnt_d[i] = nxt[i];
					end
				end
			end
			OP_HBLANK, OP_VBLANK: begin
				bi = {1'b0, item.operation == OP_VBLANK};
				sm = mode_q[bi][MB_SYNC_HI:MB_SYNC_LO];
				if (mode_q[bi][MB_SYNC]) begin
					if (item.blank_level) begin
						unique case (sm)
							SYNC_PAUSE:     run_d[bi] = 1'b0;
							SYNC_RESET:     cnt_d[bi] = '0;
							SYNC_RESET_RUN: begin
								cnt_d[bi] = '0;
								run_d[bi] = 1'b1;
							end
							default: begin
								run_d[bi]          = 1'b1;
								mode_d[bi][MB_SYNC] = 1'b0;
							end
						endcase
					end else begin
						unique case (sm)
							SYNC_PAUSE:     run_d[bi] = 1'b1;
							SYNC_RESET_RUN: run_d[bi] = 1'b0;
							default:        ;
						endcase
					end
				end
			end
			OP_READ: begin
				if (timer_ok) begin
					unique case (item.reg_select)
						REG_COUNT:  rd = cnt_q[t];
						REG_MODE: begin
							rd = {{(CNT_W-MODE_W){1'b0}}, mode_q[t]};
							mode_d[t][MB_HIT_MAX:MB_HIT_TGT] = 2'b00;
							do_irq = 1'b1;
						end
						REG_TARGET: rd = tgt_q[t];
						default:    ;
					endcase
				end
			end
			OP_WRITE: begin
				if (timer_ok) begin
					unique case (item.reg_select)
						REG_COUNT:  cnt_d[t] = item.write_data;
						REG_MODE: begin
							nm = {mode_q[t][MB_HIT_MAX:MB_REQ], item.write_data[MB_SRC_HI:0]};
							sm = nm[MB_SYNC_HI:MB_SYNC_LO];
							cnt_d[t] = '0;
							if (nm != mode_q[t]) begin
								if (t != TIMER_SLOW)
									run_d[t] = !(nm[MB_SYNC] && sm == SYNC_FREE);
								else
									run_d[t] = !nm[MB_SYNC] || sm == SYNC_RESET ||
										sm == SYNC_RESET_RUN;
							end
							mode_d[t]         = nm;
							mode_d[t][MB_REQ] = 1'b1;
							do_irq = 1'b1;
						end
						REG_TARGET: tgt_d[t] = item.write_data;
						default:    ;
					endcase
				end
			end
			default: ;
		endcase
		// interrupt line update across all timers
		if (do_irq) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				cond[i] = (mode_d[i][MB_IRQ_MAX] && mode_d[i][MB_HIT_MAX]) ||
					(mode_d[i][MB_IRQ_TGT] && mode_d[i][MB_HIT_TGT]);
				if (cond[i]) mode_d[i][MB_REQ] = 1'b0;
				if (cond[i] && !irq_d[i]) begin
					irq_d[i]  = 1'b1;
					hold_d[i] = IRQ_HOLD_TICKS;
				end else begin
					irq_d[i] = 1'b0;
				end
			end
		end
	end

	assign result.read_data = rd;
	assign result.irq_lines = irq_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			tgt_q  <= '0;
			mode_q <= '0;
			hold_q <= '0;
			run_q  <= '1;
			irq_q  <= '0;
			div_q  <= '0;
		end else if (step) begin
			cnt_q  <= cnt_d;
			tgt_q  <= tgt_d;
			mode_q <= mode_d;
			hold_q <= hold_d;
			run_q  <= run_d;
			irq_q  <= irq_d;
			div_q  <= div_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/three_channel_root_counter.sv =====
// top level of the three-channel root counter: input stage, update core, output stage
`default_nettype none

// Three 16-bit root counters driven by one stream of items on the req channel:
// system ticks, hblank/vblank level changes and bus reads/writes of the count,
// mode and target registers. Every accepted item produces exactly one transfer
// on the rsp channel carrying read_data (zero unless it was a bus read) and the
// three interrupt line levels after the item. The block takes one item per
// clock unless back pressure stalls it: an item waits in the input stage until
// the output stage is free or being drained, then the update logic computes the
// new state and the response, which is captured in the output stage at that
// edge. With no stall an item moves from the input stage straight into the
// output stage, where rsp valid rises. The output stage decouples the two sides,
// so a new item is taken while a response waits, and back pressure only stops
// input once both stages hold data. A raised interrupt line stays high for up
// to 100 ticks; the next interrupt update (mode read, mode write, or a tick in
// which a counter reaches its target or FFFFh) drops it early. Timer 2 in its
// slow clock source advances every 8th tick.
module three_channel_root_counter (
	input  wire logic clk,
	input  wire logic arst_n,
	rcnt_req_if.sink  req,
	rcnt_rsp_if.source rsp
);
	import rcnt_pkg::*;

	req_t item_s1;
	logic valid_s1;
	rsp_t result_s2;
	logic valid_s2;
	rsp_t result;
	logic advance;

	// the input stage moves on when the output stage is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	// state update happens exactly once per item, when it leaves the input stage
	rcnt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = result_s2;

endmodule

`default_nettype wire

// ===== sv/rcnt_checker.sv =====
// port-level checks for the root counter and their binding to the top level
`default_nettype none

module rcnt_port_checks (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready
);
	// items taken but not yet answered
	logic [1:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two items in flight");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response without a pending item");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd0 |-> req_ready)
		else $error("idle block refuses input");

endmodule

bind three_channel_root_counter rcnt_port_checks u_rcnt_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready)
);

`default_nettype wire
